FILE: rtl/jcb_pkg.sv
// ----------------------------------------------------------------------------
// jcb_pkg
// Shared types, byte codes and helper functions of the command block
// processor.
// ----------------------------------------------------------------------------
package jcb_pkg;

    // Default block size in bytes.
    localparam int BLOCK_BYTES_DEF = 64;
    // Most words that one readback returns.
    localparam int MAX_OUT_WORDS   = 16;

    // Register indexes of the configuration port.
    localparam int REG_CONNECTED = 0;

    // Walk control bytes.
    localparam logic [7:0] BYTE_SKIP  = 8'h00;
    localparam logic [7:0] BYTE_PAD_A = 8'hFD;
    localparam logic [7:0] BYTE_END   = 8'hFE;
    localparam logic [7:0] BYTE_PAD_B = 8'hFF;

    // Length field mask of both length bytes and error flag in the receive length byte.
    localparam logic [7:0] LEN_MASK = 8'h3F;
    localparam logic [7:0] ERR_FLAG = 8'h80;

    // Controller command codes.
    localparam logic [7:0] CODE_INFO    = 8'h00;
    localparam logic [7:0] CODE_BUTTONS = 8'h01;
    localparam logic [7:0] CODE_PAK_RD  = 8'h02;
    localparam logic [7:0] CODE_PAK_WR  = 8'h03;
    localparam logic [7:0] CODE_RESET   = 8'hFF;

    // Reply contents and minimum receive lengths.
    localparam logic [7:0] INFO_ID      = 8'h05;
    localparam logic [7:0] INFO_ZERO    = 8'h00;
    localparam logic [5:0] INFO_RX_MIN  = 6'd3;
    localparam logic [5:0] BTN_RX_MIN   = 6'd4;

    // Input item commands.
    typedef enum logic [1:0] {
        CMD_WRITE    = 2'd0,
        CMD_EXEC     = 2'd1,
        CMD_READBACK = 2'd2
    } t_cmd;

    // One accepted input word.
    typedef struct packed {
        t_cmd               cmd;
        logic [3:0]         word_index;
        logic [31:0]        write_word;
        logic [15:0]        buttons;
        logic signed [7:0]  stick_x;
        logic signed [7:0]  stick_y;
        logic               pak_present;
    } t_item;

    // Result word offered by the sequencer to the output register.
    typedef struct packed {
        logic        valid;
        logic [31:0] word;
        logic        last;
    } t_emit;

    // What a decoded command does to the block.
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_MARK,
        ACT_INFO,
        ACT_BTN
    } t_act;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_T_RD,
        S_T,
        S_RX,
        S_CODE,
        S_MARK,
        S_REP_RD,
        S_REP_WR,
        S_ADV,
        S_ACK,
        S_RB_RD,
        S_RB_OUT
    } t_state;

    // Byte of a big-endian word; lane 0 is the most significant byte.
    function automatic logic [7:0] get_byte(input logic [31:0] w, input logic [1:0] lane);
        logic [7:0] b;
        case (lane)
            2'd0:    b = w[31:24];
            2'd1:    b = w[23:16];
            2'd2:    b = w[15:8];
            default: b = w[7:0];
        endcase
        return b;
    endfunction

    // Replace one byte lane of a big-endian word.
    function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] lane,
                                             input logic [7:0] b);
        logic [31:0] r;
        r = w;
        case (lane)
            2'd0:    r[31:24] = b;
            2'd1:    r[23:16] = b;
            2'd2:    r[15:8]  = b;
            default: r[7:0]   = b;
        endcase
        return r;
    endfunction

    // Reply byte k of an info or a read-buttons answer.
    function automatic logic [7:0] reply_byte(input logic is_btn, input logic [1:0] k,
                                              input t_item item);
        logic [7:0] b;
        if (is_btn) begin
            case (k)
                2'd0:    b = item.buttons[15:8];
                2'd1:    b = item.buttons[7:0];
                2'd2:    b = item.stick_x;
                default: b = item.stick_y;
            endcase
        end else begin
            case (k)
                2'd0:    b = INFO_ID;
                2'd1:    b = INFO_ZERO;
                default: b = {7'd0, item.pak_present};
            endcase
        end
        return b;
    endfunction

endpackage

FILE: rtl/jcb_block_mem.sv
// ----------------------------------------------------------------------------
// jcb_block_mem
// Command block storage: 32-bit words, one write and one read port, read
// data registered. Words never written read as zero.
// ----------------------------------------------------------------------------
module jcb_block_mem #(
    parameter int WORDS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_re,
    input  logic [$clog2(WORDS)-1:0] i_raddr,
    input  logic                     i_we,
    input  logic [$clog2(WORDS)-1:0] i_waddr,
    input  logic [31:0]              i_wdata,
    output logic [31:0]              o_rdata
);

    logic [31:0]      r_mem [WORDS];
    logic [WORDS-1:0] r_vld;
    logic [31:0]      r_q;
    logic             r_q_vld;

    // Word array.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    // Written flags stand in for clearing the array at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_q_vld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_q_vld ? r_q : 32'd0;

endmodule

FILE: rtl/jcb_seq.sv
// ----------------------------------------------------------------------------
// jcb_seq
// Block walker and readback sequencer. Reads, modifies and writes back the
// block memory one byte lane at a time and keeps the two counters.
// ----------------------------------------------------------------------------
module jcb_seq
    import jcb_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  t_item                                  i_item,
    output logic                                   o_ready,
    input  logic [2:0]                             i_connected,
    output logic                                   o_mem_re,
    output logic [$clog2((BLOCK_BYTES+3)/4)-1:0]   o_mem_raddr,
    output logic                                   o_mem_we,
    output logic [$clog2((BLOCK_BYTES+3)/4)-1:0]   o_mem_waddr,
    output logic [31:0]                            o_mem_wdata,
    input  logic [31:0]                            i_mem_rdata,
    output t_emit                                  o_emit,
    input  logic                                   i_emit_take,
    output logic [31:0]                            o_poll_count,
    output logic [31:0]                            o_command_count
);

    localparam int WORDS   = (BLOCK_BYTES + 3) / 4;
    localparam int AW      = $clog2(WORDS);
    localparam int BA_W    = AW + 2;
    localparam int POS_W   = $clog2(BLOCK_BYTES) + 1;
    localparam int SUM_W   = $clog2(BLOCK_BYTES + 128) + 1;
    localparam int FULL_WORDS = BLOCK_BYTES / 4;
    localparam int N_OUT   = (FULL_WORDS < MAX_OUT_WORDS) ? FULL_WORDS : MAX_OUT_WORDS;

    t_state           r_state, n_state;
    t_item            r_item;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_chan;
    logic [5:0]       r_tx;
    logic [7:0]       r_rx_byte;
    logic [31:0]      r_rx_word;
    logic [BA_W-1:0]  r_reply;
    logic [1:0]       r_k;
    logic             r_is_btn;
    logic [AW-1:0]    r_rb;
    logic [31:0]      r_polls;
    logic [31:0]      r_cmds;

    logic [POS_W-1:0] pos1, pos2;
    logic [7:0]       t_byte, rx_byte, code;
    logic [5:0]       rx_sel;
    logic [SUM_W-1:0] end_sum, reply_sum;
    logic [BA_W-1:0]  rep_addr;
    logic             overrun, cmd_stop;
    t_act             act;
    t_state           done_state;
    logic             rb_last;

    // Byte positions and lengths of the command under the cursor.
    always_comb begin
        pos1      = r_pos + POS_W'(1);
        pos2      = r_pos + POS_W'(2);
        t_byte    = get_byte(i_mem_rdata, r_pos[1:0]);
        rx_byte   = get_byte(i_mem_rdata, pos1[1:0]);
        code      = get_byte(i_mem_rdata, pos2[1:0]);
        rx_sel    = (r_state == S_RX) ? (rx_byte[5:0] & LEN_MASK[5:0])
                                      : (r_rx_byte[5:0] & LEN_MASK[5:0]);
        end_sum   = SUM_W'(r_pos) + SUM_W'(2) + SUM_W'(r_tx) + SUM_W'(rx_sel);
        reply_sum = SUM_W'(r_pos) + SUM_W'(2) + SUM_W'(r_tx);
        rep_addr  = r_reply + BA_W'(r_k);
        overrun   = end_sum > SUM_W'(BLOCK_BYTES);
        cmd_stop  = (r_pos == POS_W'(BLOCK_BYTES - 1)) || ((t_byte & LEN_MASK) == 8'd0);
        done_state = (r_item.cmd == CMD_EXEC) ? S_ACK : S_RB_RD;
        rb_last   = (r_rb == AW'(N_OUT - 1));
    end

    // Command decode.
    always_comb begin
        act = ACT_NONE;
        if (r_chan != POS_W'(i_connected)) begin
            act = ACT_MARK;
        end else begin
            case (code) inside
                CODE_INFO, CODE_RESET: begin
                    act = (r_rx_byte[5:0] >= INFO_RX_MIN) ? ACT_INFO : ACT_NONE;
                end
                CODE_BUTTONS: begin
                    act = (r_rx_byte[5:0] >= BTN_RX_MIN) ? ACT_BTN : ACT_NONE;
                end
                CODE_PAK_RD, CODE_PAK_WR: begin
                    act = ACT_NONE;
                end
                default: begin
                    act = ACT_MARK;
                end
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && (i_item.cmd == CMD_EXEC || i_item.cmd == CMD_READBACK)) begin
                    n_state = S_T_RD;
                end
            end
            S_T_RD: begin
                n_state = (r_pos == POS_W'(BLOCK_BYTES)) ? done_state : S_T;
            end
            S_T: begin
                case (t_byte) inside
                    BYTE_SKIP, BYTE_PAD_A, BYTE_PAD_B: n_state = S_T_RD;
                    BYTE_END:                          n_state = done_state;
                    default:   n_state = cmd_stop ? done_state : S_RX;
                endcase
            end
            S_RX: begin
                n_state = overrun ? done_state : S_CODE;
            end
            S_CODE: begin
                unique case (act)
                    ACT_MARK:          n_state = S_MARK;
                    ACT_INFO, ACT_BTN: n_state = S_REP_RD;
                    default:           n_state = S_ADV;
                endcase
            end
            S_MARK:   n_state = S_ADV;
            S_REP_RD: n_state = S_REP_WR;
            S_REP_WR: begin
                if (r_k == (r_is_btn ? 2'd3 : 2'd2)) begin
                    n_state = S_ADV;
                end else begin
                    n_state = S_REP_RD;
                end
            end
            S_ADV: n_state = S_T_RD;
            S_ACK: begin
                if (i_emit_take) begin
                    n_state = S_IDLE;
                end
            end
            S_RB_RD: n_state = S_RB_OUT;
            S_RB_OUT: begin
                if (i_emit_take) begin
                    n_state = rb_last ? S_IDLE : S_RB_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory requests, handshake and result words.
    always_comb begin
        o_ready     = 1'b0;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_pos[BA_W-1:2];
        o_mem_we    = 1'b0;
        o_mem_waddr = AW'(i_item.word_index);
        o_mem_wdata = i_item.write_word;
        o_emit      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready  = 1'b1;
                o_mem_we = i_start && (i_item.cmd == CMD_WRITE) &&
                           (32'(i_item.word_index) < 32'(FULL_WORDS));
            end
            S_T_RD: begin
                o_mem_re    = (r_pos != POS_W'(BLOCK_BYTES));
                o_mem_raddr = r_pos[BA_W-1:2];
            end
            S_T: begin
                o_mem_raddr = pos1[BA_W-1:2];
                case (t_byte) inside
                    BYTE_SKIP, BYTE_PAD_A, BYTE_PAD_B, BYTE_END: o_mem_re = 1'b0;
                    default: o_mem_re = !cmd_stop;
                endcase
            end
            S_RX: begin
                o_mem_re    = !overrun;
                o_mem_raddr = pos2[BA_W-1:2];
            end
            S_MARK: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = pos1[BA_W-1:2];
                o_mem_wdata = put_byte(r_rx_word, pos1[1:0], r_rx_byte | ERR_FLAG);
            end
            S_REP_RD: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = rep_addr[BA_W-1:2];
            end
            S_REP_WR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = rep_addr[BA_W-1:2];
                o_mem_wdata = put_byte(i_mem_rdata, rep_addr[1:0],
                                       reply_byte(r_is_btn, r_k, r_item));
            end
            S_ACK: begin
                o_emit.valid = 1'b1;
                o_emit.word  = 32'd0;
                o_emit.last  = 1'b1;
            end
            S_RB_RD: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = r_rb;
            end
            S_RB_OUT: begin
                o_emit.valid = 1'b1;
                o_emit.word  = i_mem_rdata;
                o_emit.last  = rb_last;
            end
            default: begin
                o_mem_re = 1'b0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Walk cursor, command fields and readback index.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_item <= i_item;
                    r_pos  <= '0;
                    r_chan <= '0;
                    r_rb   <= '0;
                end
            end
            S_T: begin
                case (t_byte) inside
                    BYTE_SKIP: begin
                        r_pos  <= pos1;
                        r_chan <= r_chan + POS_W'(1);
                    end
                    BYTE_PAD_A, BYTE_PAD_B: r_pos <= pos1;
                    default: r_tx <= t_byte[5:0] & LEN_MASK[5:0];
                endcase
            end
            S_RX: begin
                r_rx_byte <= rx_byte;
                r_rx_word <= i_mem_rdata;
            end
            S_CODE: begin
                r_reply  <= reply_sum[BA_W-1:0];
                r_k      <= 2'd0;
                r_is_btn <= (act == ACT_BTN);
            end
            S_REP_WR: r_k <= r_k + 2'd1;
            S_ADV: begin
                r_pos  <= end_sum[POS_W-1:0];
                r_chan <= r_chan + POS_W'(1);
            end
            S_RB_OUT: begin
                if (i_emit_take) begin
                    r_rb <= r_rb + AW'(1);
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    // Command and poll counters, wrapping at 32 bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polls <= '0;
            r_cmds  <= '0;
        end else if (r_state == S_CODE) begin
            r_cmds <= r_cmds + 32'd1;
            if (act == ACT_BTN) begin
                r_polls <= r_polls + 32'd1;
            end
        end
    end

    assign o_poll_count    = r_polls;
    assign o_command_count = r_cmds;

endmodule

FILE: rtl/joybus_command_block_processor.sv
// ----------------------------------------------------------------------------
// joybus_command_block_processor
// Controller command block processor with block memory, walk sequencer,
// configuration register and result register.
// ----------------------------------------------------------------------------
// A write word stores one block word. An execute or a readback word
// walks the block one byte at a time through the block memory's single
// read port, each read followed by its decode. A command reads its
// length and code bytes, may mark its receive length byte, and a reply
// reads and writes back each of its three or four bytes in turn. An
// execute word ends with an acknowledgement after the walk; a readback
// word instead gives the block words, each read only once the one before
// is taken, while the result side keeps up. The next input word is taken
// as soon as the last result enters the result register.
// ----------------------------------------------------------------------------
module joybus_command_block_processor
    import jcb_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic [3:0]         i_word_index,
    input  logic [31:0]        i_write_word,
    input  logic [15:0]        i_buttons,
    input  logic signed [7:0]  i_stick_x,
    input  logic signed [7:0]  i_stick_y,
    input  logic               i_pak_present,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_read_word,
    output logic               o_last,
    output logic [31:0]        o_poll_count,
    output logic [31:0]        o_command_count,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int WORDS = (BLOCK_BYTES + 3) / 4;
    localparam int AW    = $clog2(WORDS);

    logic [2:0]    r_connected;
    logic          r_out_valid;
    logic [31:0]   r_read_word;
    logic          r_last;
    logic [31:0]   r_poll_count;
    logic [31:0]   r_command_count;

    t_item         item;
    logic          start;
    logic          mem_re, mem_we;
    logic [AW-1:0] mem_raddr, mem_waddr;
    logic [31:0]   mem_wdata, mem_rdata;
    t_emit         emit;
    logic          emit_take;
    logic [31:0]   poll_count, command_count;

    // Input word.
    always_comb begin
        item.cmd         = t_cmd'(i_cmd);
        item.word_index  = i_word_index;
        item.write_word  = i_write_word;
        item.buttons     = i_buttons;
        item.stick_x     = i_stick_x;
        item.stick_y     = i_stick_y;
        item.pak_present = i_pak_present;
    end

    assign start = i_in_valid && o_in_ready;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_connected <= 3'd0;
        end else if (psel && penable && pwrite && pready &&
                     (32'(paddr[2]) == REG_CONNECTED)) begin
            r_connected <= pwdata[2:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (32'(paddr[2]) == REG_CONNECTED) ? {29'd0, r_connected} : 32'd0;

    jcb_block_mem #(
        .WORDS (WORDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    jcb_seq #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_item          (item),
        .o_ready         (o_in_ready),
        .i_connected     (r_connected),
        .o_mem_re        (mem_re),
        .o_mem_raddr     (mem_raddr),
        .o_mem_we        (mem_we),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wdata     (mem_wdata),
        .i_mem_rdata     (mem_rdata),
        .o_emit          (emit),
        .i_emit_take     (emit_take),
        .o_poll_count    (poll_count),
        .o_command_count (command_count)
    );

    // Result register: loads whenever it is empty or being drained.
    assign emit_take = emit.valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_take) begin
            r_read_word     <= emit.word;
            r_last          <= emit.last;
            r_poll_count    <= poll_count;
            r_command_count <= command_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_word     = r_read_word;
    assign o_last          = r_last;
    assign o_poll_count    = r_poll_count;
    assign o_command_count = r_command_count;

endmodule
